FILE: rtl/frm_pkg.sv
// ----------------------------------------------------------------------------
// frm_pkg
// Shared types and constants of the fill request monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package frm_pkg;

	// Widths of the configuration port.
	localparam int unsigned CFG_DATA_WIDTH  = 16;
	localparam int unsigned CFG_INDEX_WIDTH = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE_ONE_FILL    = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FIRST_WAIT_TICKS = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LATER_WAIT_TICKS = 2'd2;

	// Reset values of the tick budgets.
	localparam logic [CFG_DATA_WIDTH-1:0] FIRST_WAIT_RESET = 16'd500;
	localparam logic [CFG_DATA_WIDTH-1:0] LATER_WAIT_RESET = 16'd3000;

	// Request kinds. Any other code behaves as a next request.
	localparam logic [1:0] KIND_FIRST = 2'd0;
	localparam logic [1:0] KIND_NEXT  = 2'd1;
	localparam logic [1:0] KIND_LAST  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD     = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	typedef struct packed {
		logic                      mode_one_fill;
		logic [CFG_DATA_WIDTH-1:0] first_wait_ticks;
		logic [CFG_DATA_WIDTH-1:0] later_wait_ticks;
	} cfg_t;

	typedef struct packed {
		logic       start_req;
		logic [1:0] request_kind;
		logic       line_c;
		logic       line_b;
	} sample_t;

	typedef struct packed {
		logic       done_res;
		logic [1:0] status;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/frm_if.sv
// ----------------------------------------------------------------------------
// frm_sample_if / frm_result_if
// Valid/ready channels for line samples and for wait results.
// ----------------------------------------------------------------------------
`default_nettype none

interface frm_sample_if;
	logic       valid;
	logic       ready;
	logic       start_req;
	logic [1:0] request_kind;
	logic       line_c;
	logic       line_b;

	modport source (output valid, start_req, request_kind, line_c, line_b, input ready);
	modport sink   (input valid, start_req, request_kind, line_c, line_b, output ready);
endinterface

interface frm_result_if;
	logic       valid;
	logic       ready;
	logic       done_res;
	logic [1:0] status;

	modport source (output valid, done_res, status, input ready);
	modport sink   (input valid, done_res, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/frm_cfg_regs.sv
// ----------------------------------------------------------------------------
// frm_cfg_regs
// Configuration registers: fill mode and the two tick budgets.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_cfg_regs
	import frm_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
	output cfg_t                            cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_one_fill    <= 1'b0;
			cfg_q.first_wait_ticks <= FIRST_WAIT_RESET;
			cfg_q.later_wait_ticks <= LATER_WAIT_RESET;
		end else if (cfg_we) begin
			// Writes to an index beyond the list fall through and are dropped.
			case (cfg_index)
				REG_MODE_ONE_FILL:    cfg_q.mode_one_fill    <= cfg_wdata[0];
				REG_FIRST_WAIT_TICKS: cfg_q.first_wait_ticks <= cfg_wdata;
				REG_LATER_WAIT_TICKS: cfg_q.later_wait_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/frm_monitor.sv
// ----------------------------------------------------------------------------
// frm_monitor
// Wait state and the per-sample decision logic of the fill request monitor.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_monitor
	import frm_pkg::*;
#(
	parameter int unsigned TICK_COUNT_WIDTH = 16
)(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    advance,
	input  wire sample_t sample,
	input  wire cfg_t    cfg,
	output result_t      result
);

	logic                        waiting_q;
	logic                        last_c_q;
	logic                        bad_seen_q;
	logic [1:0]                  kind_q;
	logic [TICK_COUNT_WIDTH-1:0] ticks_q;

	logic                        waiting_d;
	logic                        last_c_d;
	logic                        bad_seen_d;
	logic [1:0]                  kind_d;
	logic [TICK_COUNT_WIDTH-1:0] ticks_d;

	logic [CFG_DATA_WIDTH-1:0]   load_raw;
	logic [31:0]                 load_ext;
	logic                        is_last;

	assign load_raw = (sample.request_kind == KIND_FIRST) ? cfg.first_wait_ticks
	                                                      : cfg.later_wait_ticks;
	assign load_ext = {{(32 - CFG_DATA_WIDTH){1'b0}}, load_raw};

	always_comb begin
		// A start restarts the wait from fresh values on this very sample.
		if (sample.start_req) begin
			waiting_d  = 1'b1;
			last_c_d   = 1'b1;
			bad_seen_d = 1'b0;
			kind_d     = sample.request_kind;
			ticks_d    = load_ext[TICK_COUNT_WIDTH-1:0];
		end else begin
			waiting_d  = waiting_q;
			last_c_d   = last_c_q;
			bad_seen_d = bad_seen_q;
			kind_d     = kind_q;
			ticks_d    = ticks_q;
		end
		is_last = (kind_d == KIND_LAST);

		result.done_res = 1'b0;
		result.status   = ST_OK;

		if (waiting_d) begin
			if ((sample.line_c != last_c_d) && (sample.line_c || is_last)) begin
				// Request seen: the wait ends with the report gathered so far.
				waiting_d       = 1'b0;
				result.done_res = 1'b1;
				result.status   = bad_seen_d ? ST_BAD : ST_OK;
			end else begin
				last_c_d = sample.line_c;
				if (!cfg.mode_one_fill && !sample.line_b) begin
					bad_seen_d = 1'b1;
				end
				if (ticks_d <= TICK_COUNT_WIDTH'(1)) begin
					ticks_d         = '0;
					waiting_d       = 1'b0;
					result.done_res = 1'b1;
					if (cfg.mode_one_fill && (!last_c_d || is_last)) begin
						result.status = ST_OK;
					end else begin
						result.status = ST_TIMEOUT;
					end
				end else begin
					ticks_d = ticks_d - TICK_COUNT_WIDTH'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q  <= 1'b0;
			last_c_q   <= 1'b1;
			bad_seen_q <= 1'b0;
			kind_q     <= KIND_FIRST;
			ticks_q    <= '0;
		end else if (advance) begin
			waiting_q  <= waiting_d;
			last_c_q   <= last_c_d;
			bad_seen_q <= bad_seen_d;
			kind_q     <= kind_d;
			ticks_q    <= ticks_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/fill_request_monitor_core.sv
// ----------------------------------------------------------------------------
// fill_request_monitor_core
// Watches request line C and error line B of a key fill interface, one
// sample per item, and reports the end of each armed wait.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                   Width
//  samples   in         start_req, request_kind, line_c, line_b   1+2+1+1
//  results   out        done_res, status                          1+2
//  cfg_*     in         cfg_we, cfg_index, cfg_wdata              1+2+16
//
// Every sample item yields exactly one registered result item; a new sample
// is taken in every cycle the sink does not stall: one item per clock.
// The decision for a sample is made in one pass of logic over the wait state
// and lands in the result register together with the state update.
// Reset empties the result register, idles the wait and restores the default
// budgets of 500 and 3000 ticks with mode 1 fill off.
// While a result is held because the sink is stalled, no new sample is taken;
// the sample is accepted in the same cycle the held result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fill_request_monitor_core
	import frm_pkg::*;
#(
	parameter int unsigned TICK_COUNT_WIDTH = 16
)(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	frm_sample_if.sink                      samples,
	frm_result_if.source                    results,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_wdata
);

	cfg_t    cfg;
	sample_t sample;
	result_t result;
	result_t result_q;
	logic    res_valid_q;
	logic    accept;

	frm_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The sample channel is open whenever the result register is empty or
	// is being emptied in this cycle.
	assign samples.ready = !res_valid_q || results.ready;
	assign accept        = samples.valid && samples.ready;

	assign sample.start_req    = samples.start_req;
	assign sample.request_kind = samples.request_kind;
	assign sample.line_c       = samples.line_c;
	assign sample.line_b       = samples.line_b;

	frm_monitor #(
		.TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
	) u_monitor (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.sample  (sample),
		.cfg     (cfg),
		.result  (result)
	);

	// Result register: valid is control state, the payload loads on accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign results.valid    = res_valid_q;
	assign results.done_res = result_q.done_res;
	assign results.status   = result_q.status;

endmodule

`default_nettype wire

FILE: verif/frm_result_checker.sv
// ----------------------------------------------------------------------------
// frm_result_checker
// Watches the sample, result and configuration ports of the fill request
// monitor, predicts the result of every accepted sample item and compares
// each accepted result item with the oldest prediction.
// ----------------------------------------------------------------------------

module frm_result_checker
	import frm_pkg::*;
#(
	parameter int unsigned TICK_W = 16
)(
	input  logic                       clk,
	input  logic                       arst_n,
	frm_sample_if                      smp,
	frm_result_if                      res,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
	output int unsigned                mismatch_count,
	output int unsigned                results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the configuration registers.
	logic                      mode_one;
	logic [CFG_DATA_WIDTH-1:0] first_budget;
	logic [CFG_DATA_WIDTH-1:0] later_budget;

	// Shadow copy of the wait state.
	logic              armed;
	logic              last_c;
	logic              bad_flag;
	logic [1:0]        armed_kind;
	logic [TICK_W-1:0] ticks_left;

	result_t     expected_results[$];
	int unsigned failures;

	// Advances the wait state by one line sample and returns the result item.
	function automatic result_t next_wait_result(input sample_t s);
		logic [CFG_DATA_WIDTH-1:0] load;
		result_t                   r;
		r = '0;
		if (s.start_req) begin
			load       = (s.request_kind == KIND_FIRST) ? first_budget : later_budget;
			armed      = 1'b1;
			armed_kind = s.request_kind;
			ticks_left = TICK_W'(load);
			last_c     = 1'b1;
			bad_flag   = 1'b0;
		end
		if (!armed)
			return r;
		if (s.line_c != last_c) begin
			// A rise always ends the wait; a last request also ends on a fall.
			if (s.line_c || armed_kind == KIND_LAST) begin
				armed      = 1'b0;
				r.done_res = 1'b1;
				r.status   = bad_flag ? ST_BAD : ST_OK;
				return r;
			end
			last_c = s.line_c;
		end
		if (!mode_one && !s.line_b)
			bad_flag = 1'b1;
		if (ticks_left <= 1) begin
			ticks_left = '0;
			armed      = 1'b0;
			r.done_res = 1'b1;
			r.status   = (mode_one && (!last_c || armed_kind == KIND_LAST)) ? ST_OK : ST_TIMEOUT;
			return r;
		end
		ticks_left = ticks_left - 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		sample_t got_sample;
		if (!arst_n) begin
			mode_one       = 1'b0;
			first_budget   = FIRST_WAIT_RESET;
			later_budget   = LATER_WAIT_RESET;
			armed          = 1'b0;
			last_c         = 1'b1;
			bad_flag       = 1'b0;
			armed_kind     = KIND_FIRST;
			ticks_left     = '0;
			failures       = 0;
			expected_results.delete();
			mismatch_count <= 0;
			results_due    <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE_ONE_FILL:    mode_one     = cfg_wdata[0];
					REG_FIRST_WAIT_TICKS: first_budget = cfg_wdata;
					REG_LATER_WAIT_TICKS: later_budget = cfg_wdata;
					default: ;
				endcase
			end
			if (smp.valid && smp.ready) begin
				got_sample = '{smp.start_req, smp.request_kind, smp.line_c, smp.line_b};
				expected_results.push_back(next_wait_result(got_sample));
			end
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					failures++;
					if (failures <= 40)
						$display("%0t: unexpected result, expected none, got done_res=%0d status=%0d",
							$time, res.done_res, res.status);
				end else begin
					want = expected_results.pop_front();
					if (res.done_res !== want.done_res) begin
						failures++;
						if (failures <= 40)
							$display("%0t: done_res mismatch, expected %0d, got %0d",
								$time, want.done_res, res.done_res);
					end
					if (res.status !== want.status) begin
						failures++;
						if (failures <= 40)
							$display("%0t: status mismatch, expected %0d, got %0d",
								$time, want.status, res.status);
					end
				end
			end
			mismatch_count <= failures;
			results_due    <= expected_results.size();
		end
	end

endmodule

FILE: verif/tb_fill_request_monitor_core.sv
// ----------------------------------------------------------------------------
// tb_fill_request_monitor_core
// Drives line samples and configuration into the fill request monitor and
// reports the verdict. A checker instance beside the block predicts and
// compares every result item.
// ----------------------------------------------------------------------------

module tb_fill_request_monitor_core;
	import frm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TICK_W = 16;

	// The fourth register index is not decoded; writes to it must be ignored.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

	// The undefined kind code, which the block treats as a next request.
	localparam logic [1:0] KIND_THREE = 2'd3;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0]  cfg_wdata;
	int unsigned                mismatch_count;
	int unsigned                results_due;

	frm_sample_if smp ();
	frm_result_if res ();

	fill_request_monitor_core #(
		.TICK_COUNT_WIDTH(TICK_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (smp),
		.results  (res),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	frm_result_checker #(
		.TICK_W(TICK_W)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.smp           (smp),
		.res           (res),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mismatch_count(mismatch_count),
		.results_due   (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The slowest correct run is a few hundred microseconds: every item can
	// meet a full sender gap and a long receiver stall. This is far beyond it.
	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

	// The receiver repeats a 16-bit ready pattern and draws a new one after every
	// fourth pass. Some patterns never stall, some stall now and then, and some
	// hold ready low for most of the pattern. Every pattern has at least one
	// ready cycle, so a held result always drains.
	initial begin : result_stall
		logic [15:0] pattern;
		int unsigned step;
		res.ready <= 1'b0;
		pattern = 16'hffff;
		step    = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (step % 64 == 0) begin
				case ($urandom_range(0, 3))
					0:       pattern = 16'hffff;
					1:       pattern = 16'($urandom) | 16'h0001;
					2:       pattern = 16'($urandom & $urandom) | 16'h0001;
					default: pattern = 16'h8000;
				endcase
			end
			res.ready <= pattern[step % 16];
			step++;
		end
	end

	// Sender state: items left in the current burst, and items accepted.
	int unsigned burst_left;
	int unsigned sent_items;

	// Offers one sample item and returns at the edge where it is accepted.
	// Items go out in bursts; before a new burst the sender may idle for a
	// random gap. The task is always entered right after a rising edge, so
	// valid is never dropped and raised again in the same time step.
	task automatic push_sample(input logic start, input logic [1:0] kind,
		input logic c, input logic b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				smp.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		smp.valid        <= 1'b1;
		smp.start_req    <= start;
		smp.request_kind <= kind;
		smp.line_c       <= c;
		smp.line_b       <= b;
		do @(posedge clk); while (!smp.ready);
		sent_items++;
	endtask

	// Stops sending and waits until every predicted result has arrived. The
	// checker's count is registered, so the first look waits for a clock edge.
	task automatic settle();
		smp.valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
	endtask

	// Writes all three registers and the undecoded index while the result
	// path is empty. An armed wait may still be running inside the block;
	// that is how a mode change in the middle of a wait gets exercised.
	task automatic configure(input logic [CFG_DATA_WIDTH-1:0] mode_data,
		input logic [CFG_DATA_WIDTH-1:0] first, input logic [CFG_DATA_WIDTH-1:0] later);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_MODE_ONE_FILL;
		cfg_wdata <= mode_data;
		@(posedge clk);
		cfg_index <= REG_FIRST_WAIT_TICKS;
		cfg_wdata <= first;
		@(posedge clk);
		cfg_index <= REG_LATER_WAIT_TICKS;
		cfg_wdata <= later;
		@(posedge clk);
		cfg_index <= REG_UNUSED;
		cfg_wdata <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Level of line B for one sample: in a noisy sequence B dips low now and
	// then, otherwise it stays high.
	function automatic logic line_b_level(input bit noisy);
		return (noisy && $urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
	endfunction

	// Random traffic. Most of it is well-formed fill exchanges: a start with
	// C high, C held high for a while, an optional dip of C, and an optional
	// rise that ends the wait. Short budgets let some of them time out. The
	// rest is noise with every field random, including stray starts that
	// restart a running wait. The phase ends with a start that leaves a wait
	// armed across the next register update.
	task automatic run_traffic(input int unsigned count);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned hold;
		int unsigned dip;
		logic [1:0]  kind;
		bit          noisy;
		stop_at = sent_items + count;
		while (sent_items < stop_at) begin
			if ($urandom_range(0, 4) != 0) begin
				pick = $urandom_range(0, 15);
				kind = (pick < 5) ? KIND_FIRST : (pick < 10) ? KIND_NEXT :
					(pick < 15) ? KIND_LAST : KIND_THREE;
				noisy = ($urandom_range(0, 2) == 0);
				hold  = $urandom_range(0, 10);
				dip   = $urandom_range(0, 5);
				push_sample(1'b1, kind, 1'b1, line_b_level(noisy));
				repeat (hold)
					push_sample(1'b0, 2'($urandom), 1'b1, line_b_level(noisy));
				repeat (dip)
					push_sample(1'b0, 2'($urandom), 1'b0, line_b_level(noisy));
				if ($urandom_range(0, 3) != 0)
					push_sample(1'b0, 2'($urandom), 1'b1, line_b_level(noisy));
			end else begin
				repeat ($urandom_range(1, 6))
					push_sample($urandom_range(0, 5) == 0, 2'($urandom),
						1'($urandom), 1'($urandom));
			end
		end
		push_sample(1'b1, KIND_NEXT, 1'b1, 1'b1);
	endtask

	initial begin
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_MODE_ONE_FILL;
		cfg_wdata        <= '0;
		smp.valid        <= 1'b0;
		smp.start_req    <= 1'b0;
		smp.request_kind <= KIND_FIRST;
		smp.line_c       <= 1'b1;
		smp.line_b       <= 1'b1;
		burst_left = 0;
		sent_items = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: mode 0, budgets of 500 and 3000 ticks.
		// Idle ticks produce an empty result whatever the other fields hold.
		push_sample(1'b0, KIND_FIRST, 1'b1, 1'b1);
		push_sample(1'b0, KIND_THREE, 1'b0, 1'b0);
		// First request: C falls and rises again, which reads as ok.
		push_sample(1'b1, KIND_FIRST, 1'b1, 1'b1);
		push_sample(1'b0, KIND_NEXT, 1'b0, 1'b1);
		push_sample(1'b0, KIND_LAST, 1'b1, 1'b1);
		// Next request with B low on the start tick: the rise reports bad.
		push_sample(1'b1, KIND_NEXT, 1'b1, 1'b0);
		push_sample(1'b0, KIND_FIRST, 1'b1, 1'b1);
		push_sample(1'b0, KIND_FIRST, 1'b0, 1'b1);
		push_sample(1'b0, KIND_FIRST, 1'b1, 1'b1);
		// Last request ends on the fall of C.
		push_sample(1'b1, KIND_LAST, 1'b1, 1'b1);
		push_sample(1'b0, KIND_FIRST, 1'b0, 1'b1);
		// Kind three, then a restart while it is still waiting. The restart
		// samples C low, and the following rise ends it; B on the ending tick
		// is not counted.
		push_sample(1'b1, KIND_THREE, 1'b1, 1'b1);
		push_sample(1'b1, KIND_FIRST, 1'b0, 1'b1);
		push_sample(1'b0, KIND_FIRST, 1'b1, 1'b0);

		// Mode 1 with tiny budgets: B is ignored, a plain timeout stays a
		// timeout, and a timeout with C low or on a last request reads as ok.
		configure(16'd1, 16'd2, 16'd1);
		push_sample(1'b1, KIND_FIRST, 1'b1, 1'b0);
		push_sample(1'b0, KIND_FIRST, 1'b1, 1'b0);
		push_sample(1'b1, KIND_NEXT, 1'b0, 1'b1);
		push_sample(1'b1, KIND_LAST, 1'b1, 1'b1);

		// A zero budget behaves as a single tick.
		configure(16'd0, 16'd0, 16'd0);
		push_sample(1'b1, KIND_FIRST, 1'b1, 1'b1);
		push_sample(1'b1, KIND_LAST, 1'b1, 1'b0);

		// Arm a wait with a bad report in mode 0, switch to mode 1 in the
		// middle of it, and end it with a dip and a rise of C.
		configure(16'd0, 16'd3, 16'd5);
		push_sample(1'b1, KIND_NEXT, 1'b1, 1'b0);
		configure(16'd1, 16'd3, 16'd5);
		push_sample(1'b0, KIND_NEXT, 1'b0, 1'b1);
		push_sample(1'b0, KIND_NEXT, 1'b1, 1'b1);

		// Random phases over a spread of settings, the extremes among them.
		configure(16'd0, 16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)));
		run_traffic(340);
		configure(16'd1, 16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)));
		run_traffic(340);
		configure(16'd0, 16'hffff, 16'hffff);
		run_traffic(330);
		configure(16'd1, 16'hffff, 16'd1);
		run_traffic(330);
		// Only bit 0 of the mode register counts.
		configure(16'hfffe, 16'd1, 16'($urandom_range(2, 12)));
		run_traffic(330);
		configure(16'($urandom), 16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)));
		run_traffic(330);

		settle();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: sim.f
rtl/frm_pkg.sv
rtl/frm_if.sv
rtl/frm_cfg_regs.sv
rtl/frm_monitor.sv
rtl/fill_request_monitor_core.sv
verif/frm_result_checker.sv
verif/tb_fill_request_monitor_core.sv
